// ----- design/plbt_pkg.sv -----
// Shared types, constants and bit-search functions of the price level book tracker.
package plbt_pkg;

   // Fixed field widths.
   localparam int PRICE_W = 31;
   localparam int BASE_W  = 30;
   localparam int LVL_W   = 16;
   localparam int WORD_W  = 64;
   localparam int POS_W   = 6;

   // Default sizes of the book.
   localparam int LEVELS_DEF     = 1024;
   localparam int WORDS_DEF      = 16;
   localparam int COUNT_BITS_DEF = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_en;
      logic capture;
      logic rd_level;
      logic update;
      logic scan_first;
      logic scan_step;
      logic scan_check;
      logic load_rsp;
   } plbt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic rejected;
      logic need_scan;
      logic first_done;
      logic check_done;
      logic rsp_busy;
   } plbt_sts_type;

   // Position of the lowest set bit; 0 when the word is empty.
   function automatic logic [POS_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [POS_W-1:0] n;
      n = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            n = POS_W'(i);
         end
      end
      return n;
   endfunction

   // Position of the highest set bit; 0 when the word is empty.
   function automatic logic [POS_W-1:0] highest_bit(input logic [WORD_W-1:0] v);
      logic [POS_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (v[i]) begin
            n = POS_W'(i);
         end
      end
      return n;
   endfunction

endpackage

// ----- design/price_level_book_top_tracker.sv -----
// Top level of the price level book tracker: configuration port, controller and datapath.
//
// Each add or remove item gives one result with the best bid, the best ask, the order count
// of the touched level and a reject flag. From acceptance to the next acceptance an item
// passes through these steps: capture and range-check the price, read the level count and
// its occupancy word from their memories, write both back and update the best prices,
// decide on a scan and load the result register. A remove that empties the level holding
// the best price of its side searches the occupancy memory, one 64-bit word per cycle
// through its single read port. A rejected price skips the read, write-back and scan steps.
// The result register holds a finished item while the next one is worked on; an item waits
// at its end only while the previous result is still stalled. After reset the block runs a
// clearing pass over max(LEVELS, WORDS) addresses of the count and occupancy memories (1024
// at the default size), holding req_stall high; configuration writes are taken throughout.
module price_level_book_top_tracker #(
   parameter int LEVELS     = plbt_pkg::LEVELS_DEF,
   parameter int WORDS      = plbt_pkg::WORDS_DEF,
   parameter int COUNT_BITS = plbt_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic                         req_side,
   input  logic [plbt_pkg::PRICE_W-1:0] req_price,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [plbt_pkg::PRICE_W-1:0] rsp_best_bid,
   output logic [plbt_pkg::PRICE_W-1:0] rsp_best_ask,
   output logic [plbt_pkg::LVL_W-1:0]   rsp_level_orders,
   output logic                         rsp_rejected,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import plbt_pkg::*;

   plbt_cmd_type      cmd;
   plbt_sts_type      sts;
   logic [BASE_W-1:0] base_price;

   // Configuration registers.
   plbt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .base_price  (base_price)
   );

   // Sequencer.
   plbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Book storage and arithmetic.
   plbt_datapath #(
      .LEVELS     (LEVELS),
      .WORDS      (WORDS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .base_price       (base_price),
      .req_op           (req_op),
      .req_side         (req_side),
      .req_price        (req_price),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_bid     (rsp_best_bid),
      .rsp_best_ask     (rsp_best_ask),
      .rsp_level_orders (rsp_level_orders),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

// ----- design/plbt_csr.sv -----
// Configuration register file of the price level book tracker (base price).
module plbt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output logic [plbt_pkg::BASE_W-1:0] base_price
);
   import plbt_pkg::*;

   // Register index carried in the word address bit.
   localparam logic IDX_BASE_PRICE = 1'b0;

   logic [BASE_W-1:0] base_ff;
   logic              wr_en;

   // A write completes in the access phase; the port never waits.
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[2] == IDX_BASE_PRICE);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (wr_en) begin
         base_ff <= csr_pwdata[BASE_W-1:0];
      end
   end

   // Read back the selected register.
   always_comb begin
      if (csr_paddr[2] == IDX_BASE_PRICE) begin
         csr_prdata = {{(32 - BASE_W){1'b0}}, base_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign base_price = base_ff;

endmodule

// ----- design/plbt_datapath.sv -----
// Datapath of the price level book tracker: count and bitmap memories, best prices, result register.
module plbt_datapath #(
   parameter int LEVELS     = plbt_pkg::LEVELS_DEF,
   parameter int WORDS      = plbt_pkg::WORDS_DEF,
   parameter int COUNT_BITS = plbt_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  plbt_pkg::plbt_cmd_type       cmd,
   output plbt_pkg::plbt_sts_type       sts,
   input  logic [plbt_pkg::BASE_W-1:0]  base_price,
   input  logic                         req_op,
   input  logic                         req_side,
   input  logic [plbt_pkg::PRICE_W-1:0] req_price,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [plbt_pkg::PRICE_W-1:0] rsp_best_bid,
   output logic [plbt_pkg::PRICE_W-1:0] rsp_best_ask,
   output logic [plbt_pkg::LVL_W-1:0]   rsp_level_orders,
   output logic                         rsp_rejected
);
   import plbt_pkg::*;

   localparam int LB          = $clog2(LEVELS);
   localparam int OB          = $clog2(LEVELS + 1);
   localparam int WB          = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CLEAR_DEPTH = (LEVELS > WORDS) ? LEVELS : WORDS;
   localparam int CB          = $clog2(CLEAR_DEPTH);

   localparam logic OP_ADD   = 1'b0;
   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [WB-1:0]         WORD_LAST  = WB'(WORDS - 1);
   localparam logic [OB-1:0]         ASK_NONE   = OB'(LEVELS);
   localparam logic [WORD_W-1:0]     ALL_ONES   = '1;

   // Memories.
   logic [COUNT_BITS-1:0] cnt_mem [LEVELS];
   logic [WORD_W-1:0]     occ_mem [WORDS];

   // Captured item.
   logic               op_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [LB-1:0]      idx_ff;
   logic               rej_ff;
   logic               win_ff;
   logic [WB-1:0]      wad_ff;
   logic [POS_W-1:0]   bit_ff;

   // Memory read data and update results.
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [WORD_W-1:0]     occ_rd_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic                  need_scan_ff;

   // Book top and scan pointers.
   logic [PRICE_W-1:0] best_bid_ff;
   logic [OB-1:0]      best_ask_ff;
   logic [WB-1:0]      scan_addr_ff;
   logic [WB-1:0]      chk_addr_ff;
   logic [CB-1:0]      clr_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [PRICE_W-1:0] rsp_bid_ff;
   logic [PRICE_W-1:0] rsp_ask_ff;
   logic [LVL_W-1:0]   rsp_lvl_ff;
   logic               rsp_rej_ff;

   // Capture decode.
   logic [PRICE_W-1:0] diff;
   logic [PRICE_W-1:0] wnum;
   logic               in_range;

   // Update logic.
   logic [COUNT_BITS-1:0] new_cnt;
   logic [31:0]           new_cnt_ext;
   logic [WORD_W-1:0]     bit_mask;
   logic [WORD_W-1:0]     new_word;
   logic                  empty;
   logic                  hit_bid;
   logic                  hit_ask;

   // Scan logic.
   logic [WORD_W-1:0]  first_up_m;
   logic [WORD_W-1:0]  first_dn_m;
   logic [WB-1:0]      scan_next;
   logic [PRICE_W-1:0] first_bid;
   logic [OB-1:0]      first_ask;
   logic [PRICE_W-1:0] chk_bid;
   logic [OB-1:0]      chk_ask;
   logic               first_done;
   logic               check_done;

   // Range check and split of the level index into word and bit.
   assign diff     = req_price - PRICE_W'(base_price);
   assign in_range = (req_price >= PRICE_W'(base_price)) && (diff < PRICE_W'(LEVELS));
   assign wnum     = diff >> POS_W;

   // New count, new bitmap word and whether the best level was emptied.
   always_comb begin
      if (op_ff == OP_ADD) begin
         new_cnt = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
      end else begin
         new_cnt = (cnt_rd_ff == '0) ? cnt_rd_ff : cnt_rd_ff - 1'b1;
      end
      new_cnt_ext = 32'(new_cnt);
      empty       = (new_cnt == '0);
      bit_mask    = WORD_W'(1) << bit_ff;
      if (op_ff == OP_ADD) begin
         new_word = occ_rd_ff | bit_mask;
      end else if (empty) begin
         new_word = occ_rd_ff & ~bit_mask;
      end else begin
         new_word = occ_rd_ff;
      end
      hit_bid = (side_ff == SIDE_BID) && (price_ff == best_bid_ff);
      hit_ask = (side_ff == SIDE_ASK) && (OB'(idx_ff) == best_ask_ff);
   end

   // Search of the word that held the emptied level, and of each later word read.
   always_comb begin
      first_up_m = word_ff & (ALL_ONES << bit_ff);
      first_dn_m = word_ff & (ALL_ONES >> (POS_W'(WORD_W - 1) - bit_ff));
      first_ask  = OB'({wad_ff, lowest_bit(first_up_m)});
      first_bid  = PRICE_W'(32'(base_price) + 32'({wad_ff, highest_bit(first_dn_m)}));
      chk_ask    = OB'({chk_addr_ff, lowest_bit(occ_rd_ff)});
      chk_bid    = PRICE_W'(32'(base_price) + 32'({chk_addr_ff, highest_bit(occ_rd_ff)}));
      if (side_ff == SIDE_ASK) begin
         scan_next = (scan_addr_ff == WORD_LAST) ? scan_addr_ff : scan_addr_ff + 1'b1;
      end else begin
         scan_next = (scan_addr_ff == '0) ? scan_addr_ff : scan_addr_ff - 1'b1;
      end
      // The first word ends the scan on a hit, at the edge of the bitmap, or
      // for an ask level that has no bitmap word.
      if (side_ff == SIDE_ASK) begin
         first_done = !win_ff || (first_up_m != '0) || (wad_ff == WORD_LAST);
         check_done = (occ_rd_ff != '0) || (chk_addr_ff == WORD_LAST);
      end else begin
         first_done = win_ff && ((first_dn_m != '0) || (wad_ff == '0));
         check_done = (occ_rd_ff != '0) || (chk_addr_ff == '0);
      end
   end

   // Status.
   assign sts.clr_last   = (clr_ff == CB'(CLEAR_DEPTH - 1));
   assign sts.rejected   = rej_ff;
   assign sts.need_scan  = need_scan_ff;
   assign sts.first_done = first_done;
   assign sts.check_done = check_done;
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   // Count memory: clearing pass, registered read, write back.
   always_ff @(posedge clock) begin
      if (cmd.clr_en && (32'(clr_ff) < LEVELS)) begin
         cnt_mem[clr_ff[LB-1:0]] <= '0;
      end else if (cmd.update) begin
         cnt_mem[idx_ff] <= new_cnt;
      end
      if (cmd.rd_level) begin
         cnt_rd_ff <= cnt_mem[idx_ff];
      end
   end

   // Bitmap memory: clearing pass, one read port for the level and the scan.
   always_ff @(posedge clock) begin
      if (cmd.clr_en && (32'(clr_ff) < WORDS)) begin
         occ_mem[clr_ff[WB-1:0]] <= '0;
      end else if (cmd.update && win_ff) begin
         occ_mem[wad_ff] <= new_word;
      end
      if (cmd.rd_level && win_ff) begin
         occ_rd_ff <= occ_mem[wad_ff];
      end else if (cmd.scan_step) begin
         occ_rd_ff <= occ_mem[scan_addr_ff];
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_en && !sts.clr_last) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         side_ff  <= req_side;
         price_ff <= req_price;
         idx_ff   <= diff[LB-1:0];
         rej_ff   <= !in_range;
         win_ff   <= (wnum < PRICE_W'(WORDS));
         wad_ff   <= wnum[WB-1:0];
         bit_ff   <= diff[POS_W-1:0];
      end
   end

   // Update results and scan pointers.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         word_ff      <= new_word;
         lvl_ff       <= (new_cnt_ext > 32'(2 ** LVL_W - 1)) ? '1 : new_cnt_ext[LVL_W-1:0];
         need_scan_ff <= (op_ff != OP_ADD) && empty && (hit_bid || hit_ask);
      end
      if (cmd.scan_first) begin
         if (side_ff == SIDE_ASK) begin
            scan_addr_ff <= wad_ff + 1'b1;
         end else if (win_ff) begin
            scan_addr_ff <= wad_ff - 1'b1;
         end else begin
            scan_addr_ff <= WORD_LAST;
         end
      end else if (cmd.scan_step) begin
         chk_addr_ff  <= scan_addr_ff;
         scan_addr_ff <= scan_next;
      end
   end

   // Best bid and best ask.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_bid_ff <= '0;
         best_ask_ff <= ASK_NONE;
      end else if (cmd.update) begin
         if ((op_ff == OP_ADD) && (side_ff == SIDE_BID) && (best_bid_ff < price_ff)) begin
            best_bid_ff <= price_ff;
         end
         if ((op_ff == OP_ADD) && (side_ff == SIDE_ASK) && (OB'(idx_ff) < best_ask_ff)) begin
            best_ask_ff <= OB'(idx_ff);
         end
      end else if (cmd.scan_first && first_done) begin
         if (side_ff == SIDE_ASK) begin
            best_ask_ff <= (win_ff && (first_up_m != '0)) ? first_ask : ASK_NONE;
         end else begin
            best_bid_ff <= (first_dn_m != '0) ? first_bid : '0;
         end
      end else if (cmd.scan_check && check_done) begin
         if (side_ff == SIDE_ASK) begin
            best_ask_ff <= (occ_rd_ff != '0) ? chk_ask : ASK_NONE;
         end else begin
            best_bid_ff <= (occ_rd_ff != '0) ? chk_bid : '0;
         end
      end
   end

   // Result register: valid control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register: payload.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_bid_ff <= best_bid_ff;
         rsp_ask_ff <= PRICE_W'(32'(base_price) + 32'(best_ask_ff));
         rsp_lvl_ff <= rej_ff ? '0 : lvl_ff;
         rsp_rej_ff <= rej_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_bid     = rsp_bid_ff;
   assign rsp_best_ask     = rsp_ask_ff;
   assign rsp_level_orders = rsp_lvl_ff;
   assign rsp_rejected     = rsp_rej_ff;

endmodule

// ----- design/plbt_ctrl.sv -----
// Controller of the price level book tracker: sequences clearing, update, scan and result.
module plbt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output plbt_pkg::plbt_cmd_type cmd,
   input  plbt_pkg::plbt_sts_type sts
);
   import plbt_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_SCAN_FIRST,
      ST_SCAN_PRIME,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Items are taken only between events, after the clearing pass.
   assign req_stall = (state_ff != ST_IDLE);

   // Command decode per state.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_READ: begin
            cmd.rd_level = !sts.rejected;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SCAN_FIRST: begin
            cmd.scan_first = sts.need_scan;
         end
         ST_SCAN_PRIME: begin
            cmd.scan_step = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_check = 1'b1;
            cmd.scan_step  = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = !sts.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (sts.clr_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= sts.rejected ? ST_FINISH : ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= ST_SCAN_FIRST;
            end
            ST_SCAN_FIRST: begin
               if (!sts.need_scan || sts.first_done) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_SCAN_PRIME;
               end
            end
            ST_SCAN_PRIME: begin
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (sts.check_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!sts.rsp_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule
